@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for clocked assertions with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define FBC_ASSERT_HOLDS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FBC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define FBC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/fbc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbc_pkg
// shared constants and types of the frustum box culler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbc_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int NUM_PLANES = 6;
    localparam int NUM_COLS   = 4;
    localparam int NUM_AXES   = 3;
    localparam int NUM_ROWS   = 4;

    localparam int COL_IDX_W  = 2;
    localparam int M_TDATA_W  = 8;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_TEST = 1'b1
    } action_t;

endpackage

@@ sv/frustum_box_culler.sv @@
// ----------------------------------------------------------------------------
// frustum_box_culler
// culls axis-aligned boxes against six clip planes built from a matrix
// ----------------------------------------------------------------------------
// A load transfer (tuser = 0) carries one view-projection matrix column and
// is staged when it is accepted; once all four columns have been
// loaded the six planes switch over at once. A test transfer (tuser = 1)
// carries a box and yields one result, box_visible, through one stage of split
// partial products, one stage that merges them, one stage of pairwise sums and
// the output register holding the visibility bit from the final sums' signs.
// The block takes one transfer per cycle while the output side keeps up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frustum_box_culler
    import fbc_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int S_TDATA_W  = ((COL_IDX_W + 10 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // column_index, row0..row3, box_min_x/y/z, box_max_x/y/z
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // box_visible
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CW     = COORD_WIDTH;
    localparam int KW     = CW + 1;
    localparam int H      = CW / 2;
    localparam int HW     = CW - H;
    localparam int PLO_W  = KW + H + 1;
    localparam int PHI_W  = KW + HW;
    localparam int PW     = KW + CW;
    localparam int OW     = KW + FRAC_BITS;
    localparam int SW     = ((PW > OW) ? PW : OW) + 2;

    // input unpacking
    logic [COL_IDX_W-1:0]  column_index;
    logic signed [CW-1:0]  row_value [NUM_ROWS];
    logic signed [CW-1:0]  box_min   [NUM_AXES];
    logic signed [CW-1:0]  box_max   [NUM_AXES];
    action_t               action;
    logic                  load_accept;
    logic                  test_in;

    // plane storage
    logic signed [KW-1:0]  coef_reg     [NUM_PLANES][NUM_COLS];
    logic signed [KW-1:0]  coef_next    [NUM_PLANES][NUM_COLS];
    logic signed [KW-1:0]  staged_reg   [NUM_PLANES][NUM_COLS];
    logic signed [KW-1:0]  staged_next  [NUM_PLANES][NUM_COLS];
    logic [NUM_COLS-1:0]   load_mask_reg;
    logic [NUM_COLS-1:0]   load_mask_next;
    logic [NUM_COLS-1:0]   mask_merged;

    // pipeline handshake
    logic ready_a, ready_b, ready_c, ready_m;
    logic valid_a_reg, valid_a_next;
    logic valid_b_reg, valid_b_next;
    logic valid_c_reg, valid_c_next;
    logic m_valid_reg, m_valid_next;

    // stage a: partial products
    logic signed [PLO_W-1:0] plo_a_reg  [NUM_PLANES][NUM_AXES];
    logic signed [PLO_W-1:0] plo_a_next [NUM_PLANES][NUM_AXES];
    logic signed [PHI_W-1:0] phi_a_reg  [NUM_PLANES][NUM_AXES];
    logic signed [PHI_W-1:0] phi_a_next [NUM_PLANES][NUM_AXES];
    logic signed [KW-1:0]    off_a_reg  [NUM_PLANES];
    logic signed [KW-1:0]    off_a_next [NUM_PLANES];

    // stage b: full products
    logic signed [PW-1:0]    prod_b_reg  [NUM_PLANES][NUM_AXES];
    logic signed [PW-1:0]    prod_b_next [NUM_PLANES][NUM_AXES];
    logic signed [KW-1:0]    off_b_reg   [NUM_PLANES];
    logic signed [KW-1:0]    off_b_next  [NUM_PLANES];

    // stage c: pair sums
    logic signed [SW-1:0]    s01_c_reg  [NUM_PLANES];
    logic signed [SW-1:0]    s01_c_next [NUM_PLANES];
    logic signed [SW-1:0]    s2d_c_reg  [NUM_PLANES];
    logic signed [SW-1:0]    s2d_c_next [NUM_PLANES];

    // output register
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    always_comb begin
        column_index = s_tdata[COL_IDX_W-1:0];
        for (int k = 0; k < NUM_ROWS; k++) begin
            row_value[k] = s_tdata[COL_IDX_W + k * CW +: CW];
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            box_min[a] = s_tdata[COL_IDX_W + (NUM_ROWS + a) * CW +: CW];
            box_max[a] = s_tdata[COL_IDX_W + (NUM_ROWS + NUM_AXES + a) * CW +: CW];
        end
    end

    assign action      = action_t'(s_tuser);
    assign load_accept = s_tvalid && s_tready && (action == ACT_LOAD);
    assign test_in     = s_tvalid && (action == ACT_TEST);

    // handshake chain
    assign ready_m  = !m_valid_reg || m_tready;
    assign ready_c  = !valid_c_reg || ready_m;
    assign ready_b  = !valid_b_reg || ready_c;
    assign ready_a  = !valid_a_reg || ready_b;
    assign s_tready = ready_a;

    assign valid_a_next = ready_a ? test_in     : valid_a_reg;
    assign valid_b_next = ready_b ? valid_a_reg : valid_b_reg;
    assign valid_c_next = ready_c ? valid_b_reg : valid_c_reg;
    assign m_valid_next = ready_m ? valid_c_reg : m_valid_reg;

    // column load and commit
    always_comb begin
        logic signed [KW-1:0] r3;
        logic signed [KW-1:0] rk;
        staged_next    = staged_reg;
        coef_next      = coef_reg;
        load_mask_next = load_mask_reg;
        mask_merged    = load_mask_reg | (NUM_COLS'(1) << column_index);
        r3 = KW'(row_value[NUM_ROWS-1]);
        rk = '0;
        if (load_accept) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                rk = KW'(row_value[p / 2]);
                staged_next[p][column_index] = (p % 2 == 1) ? (r3 - rk) : (r3 + rk);
            end
            if (mask_merged == '1) begin
                coef_next      = staged_next;
                load_mask_next = '0;
            end else begin
                load_mask_next = mask_merged;
            end
        end
    end

    // stage a: p-vertex select and split multiply
    always_comb begin
        logic signed [CW-1:0] vtx;
        vtx = '0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                vtx = coef_reg[p][a][KW-1] ? box_min[a] : box_max[a];
                plo_a_next[p][a] = coef_reg[p][a] * $signed({1'b0, vtx[H-1:0]});
                phi_a_next[p][a] = coef_reg[p][a] * $signed(vtx[CW-1:H]);
            end
            off_a_next[p] = coef_reg[p][NUM_COLS-1];
        end
    end

    // stage b: merge partial products
    always_comb begin
        logic signed [PW-1:0] t_hi;
        logic signed [PW-1:0] t_lo;
        t_hi = '0;
        t_lo = '0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                t_hi = PW'(phi_a_reg[p][a]);
                t_lo = PW'(plo_a_reg[p][a]);
                prod_b_next[p][a] = (t_hi <<< H) + t_lo;
            end
            off_b_next[p] = off_a_reg[p];
        end
    end

    // stage c: pair sums, offset scaled to product format
    always_comb begin
        logic signed [SW-1:0] t_off;
        t_off = '0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            t_off = SW'(off_b_reg[p]);
            s01_c_next[p] = SW'(prod_b_reg[p][0]) + SW'(prod_b_reg[p][1]);
            s2d_c_next[p] = SW'(prod_b_reg[p][2]) + (t_off <<< FRAC_BITS);
        end
    end

    // final sum sign per plane
    always_comb begin
        logic signed [SW-1:0]    total;
        logic [NUM_PLANES-1:0]   outside;
        total   = '0;
        outside = '0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            total      = s01_c_reg[p] + s2d_c_reg[p];
            outside[p] = total[SW-1];
        end
        m_tdata_next = M_TDATA_W'(~|outside);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_mask_reg <= '0;
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
            valid_c_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            load_mask_reg <= load_mask_next;
            valid_a_reg   <= valid_a_next;
            valid_b_reg   <= valid_b_next;
            valid_c_reg   <= valid_c_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        staged_reg <= staged_next;
        coef_reg   <= coef_next;
        if (ready_a) begin
            plo_a_reg <= plo_a_next;
            phi_a_reg <= phi_a_next;
            off_a_reg <= off_a_next;
        end
        if (ready_b) begin
            prod_b_reg <= prod_b_next;
            off_b_reg  <= off_b_next;
        end
        if (ready_c) begin
            s01_c_reg <= s01_c_next;
            s2d_c_reg <= s2d_c_next;
        end
        if (ready_m) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    `FBC_ASSERT_HOLDS(a_mask_never_full, aclk, aresetn, load_mask_reg != '1,
        "column mask left full")
    `FBC_ASSERT_NEXT(a_commit_clears, aclk, aresetn, load_accept && mask_merged == '1,
        load_mask_reg == '0, "commit did not clear column mask")
    `FBC_ASSERT_NEXT(a_test_enters, aclk, aresetn,
        s_tvalid && s_tready && action == ACT_TEST, valid_a_reg,
        "accepted test transfer lost at entry")
    `FBC_ASSERT_SAME(a_out_from_pipe, aclk, aresetn, $rose(m_valid_reg), $past(valid_c_reg),
        "result without item in last stage")

endmodule
